// ===== hdl/sat_pkg.sv =====
package sat_pkg;

  localparam int CMD_W    = 3;
  localparam int COORD_W  = 11;
  localparam int CFG_W    = 7;
  localparam int VAL_W    = 32;
  localparam int OSUM_W   = 48;
  localparam int STAT_W   = 2;
  localparam int QUO_W    = COORD_W + 1;
  localparam int MUL_W    = 2 * QUO_W;
  localparam int K_W      = 4;

  localparam logic [CMD_W-1:0] CMD_ADD    = 3'd0;
  localparam logic [CMD_W-1:0] CMD_FREEZE = 3'd1;
  localparam logic [CMD_W-1:0] CMD_RECT   = 3'd2;
  localparam logic [CMD_W-1:0] CMD_TORUS  = 3'd3;
  localparam logic [CMD_W-1:0] CMD_CLEAR  = 3'd4;

  localparam logic [STAT_W-1:0] STAT_OK    = 2'd0;
  localparam logic [STAT_W-1:0] STAT_PHASE = 2'd1;
  localparam logic [STAT_W-1:0] STAT_RANGE = 2'd2;

  localparam logic REG_ROWS = 1'b0;
  localparam logic REG_COLS = 1'b1;

  localparam logic [K_W-1:0] K_RECT_LAST  = 4'd3;
  localparam logic [K_W-1:0] K_TORUS_LAST = 4'd8;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_ADD_RD,
    ST_ADD_WR,
    ST_FRZ_CUR,
    ST_FRZ_UP,
    ST_FRZ_WR,
    ST_DIV,
    ST_PREP,
    ST_CORNER,
    ST_MUL,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic                     done;
    logic signed [QUO_W-1:0]  quo;
    logic [CFG_W-1:0]         rem;
  } div_res_t;

endpackage

// ===== hdl/sat_ram.sv =====
module sat_ram #(
  parameter int WIDTH = 48,
  parameter int DEPTH = 4096
) (
  input  logic                             clk,
  input  logic                             we,
  input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] addr,
  input  logic [WIDTH-1:0]                 wdata,
  output logic [WIDTH-1:0]                 rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // read-first single port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

// ===== hdl/sat_div.sv =====
module sat_div (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start,
  input  logic signed [sat_pkg::COORD_W-1:0] num,
  input  logic [sat_pkg::CFG_W-1:0]         den,
  output sat_pkg::div_res_t                 res
);
  import sat_pkg::*;

  localparam int CNT_W = $clog2(COORD_W);

  logic                 busy_r;
  logic                 done_r;
  logic [CNT_W-1:0]     cnt_r;
  logic [COORD_W-1:0]   quo_r;
  logic [CFG_W:0]       rem_r;
  logic [CFG_W-1:0]     den_r;
  logic                 neg_r;
  logic [CFG_W:0]       trial;
  logic                 ge;

  assign trial = {rem_r[CFG_W-1:0], quo_r[COORD_W-1]};
  assign ge    = trial >= {1'b0, den_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
        neg_r  <= num[COORD_W-1];
        quo_r  <= num[COORD_W-1] ? COORD_W'(-num) : COORD_W'(num);
        rem_r  <= '0;
        den_r  <= den;
      end else if (busy_r) begin
        rem_r <= ge ? trial - {1'b0, den_r} : trial;
        quo_r <= {quo_r[COORD_W-2:0], ge};
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == CNT_W'(COORD_W - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // floor semantics for negative dividends
  always_comb begin
    res.done = done_r;
    if (neg_r && rem_r != '0) begin
      res.quo = -$signed({1'b0, quo_r}) - QUO_W'(1);
      res.rem = den_r - rem_r[CFG_W-1:0];
    end else if (neg_r) begin
      res.quo = -$signed({1'b0, quo_r});
      res.rem = '0;
    end else begin
      res.quo = $signed({1'b0, quo_r});
      res.rem = rem_r[CFG_W-1:0];
    end
  end

endmodule

// ===== hdl/sat_mul.sv =====
module sat_mul #(
  parameter int PW = 48,
  parameter int MW = 24
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  logic [PW-1:0] mcand,
  input  logic [MW-1:0] mult,
  output logic [PW-1:0] prod,
  output logic          done
);

  localparam int CNT_W = $clog2(MW + 1);

  logic              busy_r;
  logic              done_r;
  logic [CNT_W-1:0]  cnt_r;
  logic [PW-1:0]     mcand_r;
  logic [MW-1:0]     mult_r;
  logic [PW-1:0]     prod_r;

  // shift-add, one multiplier bit per cycle, product wraps at PW bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r  <= 1'b1;
        cnt_r   <= '0;
        mcand_r <= mcand;
        mult_r  <= mult;
        prod_r  <= '0;
      end else if (busy_r) begin
        if (mult_r[0]) begin
          prod_r <= prod_r + mcand_r;
        end
        mcand_r <= {mcand_r[PW-2:0], 1'b0};
        mult_r  <= {1'b0, mult_r[MW-1:1]};
        cnt_r   <= cnt_r + 1'b1;
        if (cnt_r == CNT_W'(MW - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign prod = prod_r;
  assign done = done_r;

endmodule

// ===== hdl/summed_area_table_query.sv =====
// One item at a time, taken only in the idle state: an add reads then writes
// one cell, freeze walks every grid cell, a rectangle query reads four corners,
// and a torus query runs four serial divisions, nine table reads and three serial
// multiplies; the single table RAM port and the serial units set the pace. Reset
// (and every clear item) sweeps all MAX_ROWS*MAX_COLS table cells to zero, no
// item taken.
module summed_area_table_query #(
  parameter int MAX_ROWS    = 64,
  parameter int MAX_COLS    = 64,
  parameter int SUM_WIDTH   = 48,
  parameter int VALUE_WIDTH = 32
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [sat_pkg::CMD_W-1:0]           in_command,
  input  logic signed [sat_pkg::COORD_W-1:0]  in_row_a,
  input  logic signed [sat_pkg::COORD_W-1:0]  in_col_a,
  input  logic signed [sat_pkg::COORD_W-1:0]  in_row_b,
  input  logic signed [sat_pkg::COORD_W-1:0]  in_col_b,
  input  logic signed [sat_pkg::VAL_W-1:0]    in_value,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic signed [sat_pkg::OSUM_W-1:0]   out_sum,
  output logic [sat_pkg::STAT_W-1:0]          out_status,
  input  logic                                cfg_we,
  input  logic                                cfg_index,
  input  logic [sat_pkg::CFG_W-1:0]           cfg_wdata
);
  import sat_pkg::*;

  localparam int DEPTH = MAX_ROWS * MAX_COLS;
  localparam int AW    = DEPTH > 1 ? $clog2(DEPTH) : 1;
  localparam int RW    = MAX_ROWS > 1 ? $clog2(MAX_ROWS) : 1;
  localparam int CW    = MAX_COLS > 1 ? $clog2(MAX_COLS) : 1;
  localparam int VE    = VALUE_WIDTH < VAL_W ? VALUE_WIDTH : VAL_W;
  localparam int SW    = COORD_W + 1;

  // table cell address: row-major, MAX_COLS words per row
  function automatic logic [AW-1:0] cell_addr(input logic [RW-1:0] r, input logic [CW-1:0] c);
    cell_addr = AW'(r) * AW'(MAX_COLS) + AW'(c);
  endfunction

  // ---------------- configuration ----------------
  logic [CFG_W-1:0] rows_r, cols_r;
  logic [CFG_W-1:0] h, w;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rows_r <= CFG_W'(64);
      cols_r <= CFG_W'(64);
    end else if (cfg_we) begin
      if (cfg_index == REG_ROWS) begin
        rows_r <= cfg_wdata;
      end else begin
        cols_r <= cfg_wdata;
      end
    end
  end

  // effective size: zero acts as one, clamp to the array bounds
  always_comb begin
    if (rows_r == '0) begin
      h = CFG_W'(1);
    end else if (32'(rows_r) > MAX_ROWS) begin
      h = CFG_W'(MAX_ROWS);
    end else begin
      h = rows_r;
    end
    if (cols_r == '0) begin
      w = CFG_W'(1);
    end else if (32'(cols_r) > MAX_COLS) begin
      w = CFG_W'(MAX_COLS);
    end else begin
      w = cols_r;
    end
  end

  logic signed [SW-1:0] hs, ws;
  assign hs = $signed({{(SW-CFG_W){1'b0}}, h});
  assign ws = $signed({{(SW-CFG_W){1'b0}}, w});

  // ---------------- state ----------------
  state_t state_r, state_nxt;

  logic                       frozen_r;
  logic                       clr_reply_r;
  logic [AW-1:0]              clr_cnt_r;
  logic [CMD_W-1:0]           cmd_r;
  logic signed [COORD_W-1:0]  ra_r, ca_r, rb_r, cb_r;
  logic [SUM_WIDTH-1:0]       val_r;
  logic [STAT_W-1:0]          stat_r;
  logic [SUM_WIDTH-1:0]       acc_r, t0_r, t1_r, t2_r;

  // freeze walk
  logic [RW-1:0]              y_r;
  logic [CW-1:0]              x_r;
  logic [SUM_WIDTH-1:0]       cur_r, left_r, diag_r;

  // corner fetch pipeline
  logic [K_W-1:0]             k_r, pk_r, last_k_r;
  logic                       pv_r, pz_r;

  // torus helpers
  logic [1:0]                 idx_r;
  logic                       wait_r;
  logic signed [QUO_W-1:0]    qra_r, qrb_r, qca_r, qcb_r;
  logic [QUO_W-1:0]           dr_r, dc_r;
  logic [MUL_W-1:0]           drdc_r;

  // output register
  logic                       out_valid_r;
  logic signed [OSUM_W-1:0]   out_sum_r;
  logic [STAT_W-1:0]          out_status_r;

  // ---------------- memory ----------------
  logic                 mem_we;
  logic [AW-1:0]        mem_addr;
  logic [SUM_WIDTH-1:0] mem_wdata, mem_rdata;

  sat_ram #(.WIDTH(SUM_WIDTH), .DEPTH(DEPTH)) u_ram (
    .clk   (clk),
    .we    (mem_we),
    .addr  (mem_addr),
    .wdata (mem_wdata),
    .rdata (mem_rdata)
  );

  // ---------------- serial units ----------------
  logic                       div_start;
  logic signed [COORD_W-1:0]  div_num;
  logic [CFG_W-1:0]           div_den;
  div_res_t                   div_res;

  sat_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .res   (div_res)
  );

  logic                 mul_start, mul_done;
  logic [SUM_WIDTH-1:0] mul_mcand, mul_prod;
  logic [MUL_W-1:0]     mul_mult;

  sat_mul #(.PW(SUM_WIDTH), .MW(MUL_W)) u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .start (mul_start),
    .mcand (mul_mcand),
    .mult  (mul_mult),
    .prod  (mul_prod),
    .done  (mul_done)
  );

  // division order: rows b, a, then columns b, a
  always_comb begin
    case (idx_r)
      2'd0:    div_num = rb_r;
      2'd1:    div_num = ra_r;
      2'd2:    div_num = cb_r;
      default: div_num = ca_r;
    endcase
    div_den = idx_r[1] ? w : h;
  end

  // products: T0*(dr*dc), T1*dr, T2*dc
  always_comb begin
    case (idx_r)
      2'd0: begin
        mul_mcand = t0_r;
        mul_mult  = drdc_r;
      end
      2'd1: begin
        mul_mcand = t1_r;
        mul_mult  = MUL_W'(dr_r);
      end
      default: begin
        mul_mcand = t2_r;
        mul_mult  = MUL_W'(dc_r);
      end
    endcase
  end

  // ---------------- input decode ----------------
  logic                  in_fire;
  logic signed [SW-1:0]  ra_i, ca_i, rb_i, cb_i;
  logic                  add_ok, rect_ok, torus_ok;
  logic signed [63:0]    val_ext;

  assign in_ready = (state_r == ST_IDLE);
  assign in_fire  = in_valid && in_ready;

  assign ra_i = SW'(in_row_a);
  assign ca_i = SW'(in_col_a);
  assign rb_i = SW'(in_row_b);
  assign cb_i = SW'(in_col_b);

  assign add_ok   = ra_i >= 0 && ra_i < hs && ca_i >= 0 && ca_i < ws;
  assign rect_ok  = ra_i >= 0 && ra_i <= rb_i && rb_i <= hs &&
                    ca_i >= 0 && ca_i <= cb_i && cb_i <= ws;
  assign torus_ok = rb_i >= ra_i && cb_i >= ca_i;
  assign val_ext  = 64'($signed(in_value[VE-1:0]));

  // ---------------- address generation ----------------
  logic signed [SW-1:0] cr, cc, crm1, ccm1;
  logic                 c_zero;
  logic [AW-1:0]        corner_addr, add_addr, frz_addr, up_addr;

  // corner list: four rectangle corners, then the torus tile terms
  always_comb begin
    case (k_r)
      4'd0:    begin cr = SW'(rb_r); cc = SW'(cb_r); end
      4'd1:    begin cr = SW'(rb_r); cc = SW'(ca_r); end
      4'd2:    begin cr = SW'(ra_r); cc = SW'(cb_r); end
      4'd3:    begin cr = SW'(ra_r); cc = SW'(ca_r); end
      4'd4:    begin cr = hs;        cc = ws;        end
      4'd5:    begin cr = hs;        cc = SW'(cb_r); end
      4'd6:    begin cr = hs;        cc = SW'(ca_r); end
      4'd7:    begin cr = SW'(rb_r); cc = ws;        end
      4'd8:    begin cr = SW'(ra_r); cc = ws;        end
      default: begin cr = '0;        cc = '0;        end
    endcase
    c_zero      = cr <= 0 || cc <= 0;
    crm1        = cr - SW'(1);
    ccm1        = cc - SW'(1);
    corner_addr = cell_addr(crm1[RW-1:0], ccm1[CW-1:0]);
  end

  assign add_addr = cell_addr(ra_r[RW-1:0], ca_r[CW-1:0]);
  assign frz_addr = cell_addr(y_r, x_r);
  assign up_addr  = cell_addr(y_r - 1'b1, x_r);

  // ---------------- freeze datapath ----------------
  logic [SUM_WIDTH-1:0] up_val, frz_new;
  logic                 x_last, y_last;

  assign up_val  = (y_r == '0) ? '0 : mem_rdata;
  assign frz_new = cur_r + left_r + up_val - diag_r;
  assign x_last  = SW'(x_r) == SW'(w) - SW'(1);
  assign y_last  = SW'(y_r) == SW'(h) - SW'(1);

  // ---------------- corner accumulate ----------------
  logic [SUM_WIDTH-1:0] c_val, c_sval;
  logic                 c_neg;

  assign c_val  = pz_r ? '0 : mem_rdata;
  assign c_neg  = pk_r == 4'd1 || pk_r == 4'd2 || pk_r == 4'd6 || pk_r == 4'd8;
  assign c_sval = c_neg ? -c_val : c_val;

  // ---------------- control ----------------
  always_comb begin
    state_nxt = state_r;
    mem_we    = 1'b0;
    mem_addr  = corner_addr;
    mem_wdata = '0;
    div_start = 1'b0;
    mul_start = 1'b0;
    case (state_r)
      ST_CLEAR: begin
        mem_we   = 1'b1;
        mem_addr = clr_cnt_r;
        if (clr_cnt_r == AW'(DEPTH - 1)) begin
          state_nxt = clr_reply_r ? ST_DONE : ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_fire) begin
          case (in_command)
            CMD_ADD:    state_nxt = (!frozen_r && add_ok) ? ST_ADD_RD : ST_DONE;
            CMD_FREEZE: state_nxt = !frozen_r ? ST_FRZ_CUR : ST_DONE;
            CMD_RECT:   state_nxt = (frozen_r && rect_ok) ? ST_CORNER : ST_DONE;
            CMD_TORUS:  state_nxt = (frozen_r && torus_ok) ? ST_DIV : ST_DONE;
            CMD_CLEAR:  state_nxt = ST_CLEAR;
            default:    state_nxt = ST_DONE;
          endcase
        end
      end
      ST_ADD_RD: begin
        mem_addr  = add_addr;
        state_nxt = ST_ADD_WR;
      end
      ST_ADD_WR: begin
        mem_addr  = add_addr;
        mem_we    = 1'b1;
        mem_wdata = mem_rdata + val_r;
        state_nxt = ST_DONE;
      end
      ST_FRZ_CUR: begin
        mem_addr  = frz_addr;
        state_nxt = ST_FRZ_UP;
      end
      ST_FRZ_UP: begin
        mem_addr  = up_addr;
        state_nxt = ST_FRZ_WR;
      end
      ST_FRZ_WR: begin
        mem_addr  = frz_addr;
        mem_we    = 1'b1;
        mem_wdata = frz_new;
        state_nxt = (x_last && y_last) ? ST_DONE : ST_FRZ_CUR;
      end
      ST_DIV: begin
        div_start = !wait_r;
        if (div_res.done && idx_r == 2'd3) begin
          state_nxt = ST_PREP;
        end
      end
      ST_PREP: begin
        state_nxt = ST_CORNER;
      end
      ST_CORNER: begin
        if (pv_r && pk_r == last_k_r) begin
          state_nxt = (cmd_r == CMD_TORUS) ? ST_MUL : ST_DONE;
        end
      end
      ST_MUL: begin
        mul_start = !wait_r;
        if (mul_done && idx_r == 2'd2) begin
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!out_valid_r || out_ready) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  // ---------------- datapath ----------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frozen_r    <= 1'b0;
      clr_reply_r <= 1'b0;
      clr_cnt_r   <= '0;
      out_valid_r <= 1'b0;
      pv_r        <= 1'b0;
      wait_r      <= 1'b0;
    end else begin
      // ST_DONE reloads the output register itself
      if (out_valid_r && out_ready && state_r != ST_DONE) begin
        out_valid_r <= 1'b0;
      end
      drdc_r <= dr_r * dc_r;

      case (state_r)
        ST_CLEAR: begin
          clr_cnt_r <= clr_cnt_r + 1'b1;
        end
        ST_IDLE: begin
          if (in_fire) begin
            cmd_r    <= in_command;
            ra_r     <= in_row_a;
            ca_r     <= in_col_a;
            rb_r     <= in_row_b;
            cb_r     <= in_col_b;
            val_r    <= SUM_WIDTH'(val_ext);
            acc_r    <= '0;
            t0_r     <= '0;
            t1_r     <= '0;
            t2_r     <= '0;
            y_r      <= '0;
            x_r      <= '0;
            left_r   <= '0;
            diag_r   <= '0;
            k_r      <= '0;
            pv_r     <= 1'b0;
            idx_r    <= '0;
            wait_r   <= 1'b0;
            last_k_r <= (in_command == CMD_TORUS) ? K_TORUS_LAST : K_RECT_LAST;
            case (in_command)
              CMD_ADD: begin
                if (frozen_r) begin
                  stat_r <= STAT_PHASE;
                end else if (!add_ok) begin
                  stat_r <= STAT_RANGE;
                end else begin
                  stat_r <= STAT_OK;
                end
              end
              CMD_FREEZE: begin
                if (frozen_r) begin
                  stat_r <= STAT_PHASE;
                end else begin
                  stat_r   <= STAT_OK;
                  frozen_r <= 1'b1;
                end
              end
              CMD_RECT: begin
                if (!frozen_r) begin
                  stat_r <= STAT_PHASE;
                end else if (!rect_ok) begin
                  stat_r <= STAT_RANGE;
                end else begin
                  stat_r <= STAT_OK;
                end
              end
              CMD_TORUS: begin
                if (!frozen_r) begin
                  stat_r <= STAT_PHASE;
                end else if (!torus_ok) begin
                  stat_r <= STAT_RANGE;
                end else begin
                  stat_r <= STAT_OK;
                end
              end
              CMD_CLEAR: begin
                stat_r      <= STAT_OK;
                frozen_r    <= 1'b0;
                clr_reply_r <= 1'b1;
                clr_cnt_r   <= '0;
              end
              default: begin
                stat_r <= STAT_OK;
              end
            endcase
          end
        end
        ST_FRZ_UP: begin
          cur_r <= mem_rdata;
        end
        ST_FRZ_WR: begin
          if (x_last) begin
            x_r    <= '0;
            left_r <= '0;
            diag_r <= '0;
            y_r    <= y_r + 1'b1;
          end else begin
            x_r    <= x_r + 1'b1;
            left_r <= frz_new;
            diag_r <= up_val;
          end
        end
        ST_DIV: begin
          if (!wait_r) begin
            wait_r <= 1'b1;
          end
          if (div_res.done) begin
            wait_r <= 1'b0;
            idx_r  <= idx_r + 1'b1;
            // coordinate registers take the in-tile remainder
            case (idx_r)
              2'd0: begin
                qrb_r <= div_res.quo;
                rb_r  <= COORD_W'(div_res.rem);
              end
              2'd1: begin
                qra_r <= div_res.quo;
                ra_r  <= COORD_W'(div_res.rem);
              end
              2'd2: begin
                qcb_r <= div_res.quo;
                cb_r  <= COORD_W'(div_res.rem);
              end
              default: begin
                qca_r <= div_res.quo;
                ca_r  <= COORD_W'(div_res.rem);
              end
            endcase
          end
        end
        ST_PREP: begin
          dr_r <= QUO_W'(qrb_r - qra_r);
          dc_r <= QUO_W'(qcb_r - qca_r);
        end
        ST_CORNER: begin
          // past the last corner the issue side drops pv_r
          if (k_r <= last_k_r) begin
            pv_r <= 1'b1;
            pz_r <= c_zero;
            pk_r <= k_r;
            k_r  <= k_r + 1'b1;
          end else begin
            pv_r <= 1'b0;
          end
          if (pv_r) begin
            case (pk_r)
              4'd0, 4'd1, 4'd2, 4'd3: acc_r <= acc_r + c_sval;
              4'd4:                   t0_r  <= c_val;
              4'd5, 4'd6:             t1_r  <= t1_r + c_sval;
              4'd7, 4'd8:             t2_r  <= t2_r + c_sval;
              default: ;
            endcase
          end
          if (pv_r && pk_r == last_k_r) begin
            idx_r  <= '0;
            wait_r <= 1'b0;
          end
        end
        ST_MUL: begin
          if (!wait_r) begin
            wait_r <= 1'b1;
          end
          if (mul_done) begin
            wait_r <= 1'b0;
            idx_r  <= idx_r + 1'b1;
            acc_r  <= acc_r + mul_prod;
          end
        end
        ST_DONE: begin
          if (!out_valid_r || out_ready) begin
            out_valid_r  <= 1'b1;
            out_sum_r    <= OSUM_W'(64'($signed(acc_r)));
            out_status_r <= stat_r;
            clr_reply_r  <= 1'b0;
          end
        end
        default: ;
      endcase
    end
  end

  assign out_valid  = out_valid_r;
  assign out_sum    = out_sum_r;
  assign out_status = out_status_r;

endmodule
